@@ rtl/core/bounded_set_store_defines.svh @@
// Assertion macros used by the checker file of the bounded set store.
`ifndef BOUNDED_SET_STORE_DEFINES_SVH
`define BOUNDED_SET_STORE_DEFINES_SVH

// Property sampled on clk and ignored while reset is asserted.
`define BSS_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property sampled on clk at every edge, reset cycles included.
`define BSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bss_pkg.sv @@
// Shared constants, codes and types of the bounded set store.
`default_nettype none

package bss_pkg;

  // Storage geometry
  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 8;
  localparam int LIM_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Word field widths
  localparam int MODE_W  = 3;
  localparam int ELEM_W  = 32;
  localparam int COUNT_W = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MEMBER     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ITER_START = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ITER_NEXT  = 3'd4;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // Entry store access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ELEM_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

@@ rtl/core/bss_if.sv @@
// Valid/ready channel interfaces for the operation and result words.
`default_nettype none

interface bss_in_if;
  logic                        valid;
  logic                        ready;
  logic [bss_pkg::MODE_W-1:0]  mode;
  bss_pkg::elem_t              element;

  modport source (output valid, output mode, output element, input ready);
  modport sink   (input valid, input mode, input element, output ready);
endinterface

interface bss_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  bss_pkg::elem_t              value;
  logic [bss_pkg::COUNT_W-1:0] count;
  logic                        empty_res;

  modport source (output valid, output ok, output value, output count, output empty_res,
                  input ready);
  modport sink   (input valid, input ok, input value, input count, input empty_res,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/bss_ram.sv @@
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module bss_ram (
  input  wire logic                          clk,
  input  wire bss_pkg::ram_req_t             req,
  output logic [bss_pkg::ELEM_W-1:0]         rdata
);

  logic [bss_pkg::ELEM_W-1:0] mem [bss_pkg::DEPTH];

  // Write and read in the same cycle; read data is registered and lands in the next cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/bounded_set_store.sv @@
// Top level of the bounded set store: sequencer, entry store and result register.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------
//   in_ch    | in  | valid/ready   | mode, element
//   out_ch   | out | valid/ready   | ok, value, count, empty_res
//   cfg      | in  | cfg_we        | cfg_wdata (capacity)
//
// One word at a time. The scan reads one stored entry per cycle through the
// single read port of the entry store; a remove that finds its value shifts
// the later entries down by one, the shift going on from where the scan stopped.
// Reset (rst_n, synchronous) empties the set and sets capacity to 128.
// A result waits in the output register while the next word is processed;
// a further result holds the sequencer until that register is taken.
`default_nettype none

module bounded_set_store (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bss_in_if.sink                          in_ch,
  bss_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [bss_pkg::CAP_W-1:0]  cfg_wdata
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [bss_pkg::OCC_W-1:0]     occ_r, occ_nxt;
  logic [bss_pkg::OCC_W-1:0]     cur_r, cur_nxt;
  logic [bss_pkg::OCC_W-1:0]     idx_r, idx_nxt;
  logic                          pend_r, pend_nxt;
  logic [bss_pkg::ADDR_W-1:0]    pidx_r, pidx_nxt;
  logic [bss_pkg::MODE_W-1:0]    mode_r, mode_nxt;
  bss_pkg::elem_t                elem_r, elem_nxt;
  logic                          ok_res_r, ok_res_nxt;
  bss_pkg::elem_t                val_res_r, val_res_nxt;
  logic [bss_pkg::CAP_W-1:0]     cap_r;

  logic                          ov_r, ov_nxt;
  logic                          o_ok_r;
  bss_pkg::elem_t                o_val_r;
  logic [bss_pkg::COUNT_W-1:0]   o_cnt_r;
  logic                          o_emp_r;

  bss_pkg::ram_req_t             req;
  logic [bss_pkg::ELEM_W-1:0]    rd_data;

  logic [bss_pkg::LIM_W-1:0]     cap_ext;
  logic [bss_pkg::LIM_W-1:0]     depth_ext;
  logic [bss_pkg::LIM_W-1:0]     limit;
  logic                          room;
  logic                          hit;
  logic                          out_load;

  bss_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rd_data)
  );

  // Capacity limit saturates at the store depth
  assign cap_ext   = bss_pkg::LIM_W'(cap_r);
  assign depth_ext = bss_pkg::LIM_W'(bss_pkg::DEPTH);
  assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
  assign room      = bss_pkg::LIM_W'(occ_r) < limit;

  // Compare of the entry read in the previous cycle
  assign hit = pend_r && (rd_data == elem_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load    = (state_r == S_FIN) && (!ov_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    occ_nxt     = occ_r;
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    pidx_nxt    = pidx_r;
    mode_nxt    = mode_r;
    elem_nxt    = elem_r;
    ok_res_nxt  = ok_res_r;
    val_res_nxt = val_res_r;
    req.we      = 1'b0;
    req.waddr   = occ_r[bss_pkg::ADDR_W-1:0];
    req.wdata   = elem_r;
    req.raddr   = idx_r[bss_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt    = in_ch.mode;
          elem_nxt    = in_ch.element;
          ok_res_nxt  = 1'b0;
          val_res_nxt = '0;
          idx_nxt     = '0;
          pend_nxt    = 1'b0;
          unique case (in_ch.mode)
            bss_pkg::MODE_INSERT: begin
              state_nxt = room ? S_SCAN : S_FIN;
            end
            bss_pkg::MODE_REMOVE,
            bss_pkg::MODE_MEMBER: begin
              state_nxt = S_SCAN;
            end
            bss_pkg::MODE_ITER_START: begin
              cur_nxt   = '0;
              state_nxt = S_FIN;
            end
            bss_pkg::MODE_ITER_NEXT: begin
              if (cur_r < occ_r) begin
                req.raddr = cur_r[bss_pkg::ADDR_W-1:0];
                state_nxt = S_ITER;
              end else begin
                state_nxt = S_FIN;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // Walk the entries, one read issued and one compare per cycle
      S_SCAN: begin
        if (hit) begin
          if (mode_r == bss_pkg::MODE_REMOVE) begin
            idx_nxt   = bss_pkg::OCC_W'(pidx_r) + bss_pkg::OCC_W'(1);
            pend_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end else begin
            ok_res_nxt = 1'b1;
            state_nxt  = S_FIN;
          end
        end else if (idx_r < occ_r) begin
          req.raddr = idx_r[bss_pkg::ADDR_W-1:0];
          pend_nxt  = 1'b1;
          pidx_nxt  = idx_r[bss_pkg::ADDR_W-1:0];
          idx_nxt   = idx_r + bss_pkg::OCC_W'(1);
        end else begin
          // absent: insert appends at the end
          if (mode_r == bss_pkg::MODE_INSERT) begin
            req.we     = 1'b1;
            req.waddr  = occ_r[bss_pkg::ADDR_W-1:0];
            req.wdata  = elem_r;
            occ_nxt    = occ_r + bss_pkg::OCC_W'(1);
            ok_res_nxt = 1'b1;
          end
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end
      end

      // Move later entries down by one: read entry k, write it at k-1
      S_SHIFT: begin
        if (pend_r) begin
          req.we    = 1'b1;
          req.waddr = pidx_r - bss_pkg::ADDR_W'(1);
          req.wdata = rd_data;
        end
        if (idx_r < occ_r) begin
          req.raddr = idx_r[bss_pkg::ADDR_W-1:0];
          pend_nxt  = 1'b1;
          pidx_nxt  = idx_r[bss_pkg::ADDR_W-1:0];
          idx_nxt   = idx_r + bss_pkg::OCC_W'(1);
        end else begin
          pend_nxt   = 1'b0;
          occ_nxt    = occ_r - bss_pkg::OCC_W'(1);
          ok_res_nxt = 1'b1;
          state_nxt  = S_FIN;
        end
      end

      // Entry at the cursor is on the read port
      S_ITER: begin
        val_res_nxt = rd_data;
        ok_res_nxt  = 1'b1;
        cur_nxt     = cur_r + bss_pkg::OCC_W'(1);
        state_nxt   = S_FIN;
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      cur_r   <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      cap_r   <= bss_pkg::CAP_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      cur_r   <= cur_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    pidx_r    <= pidx_nxt;
    mode_r    <= mode_nxt;
    elem_r    <= elem_nxt;
    ok_res_r  <= ok_res_nxt;
    val_res_r <= val_res_nxt;
  end

  // Output register
  always_comb begin
    if (out_load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_ok_r  <= ok_res_r;
      o_val_r <= val_res_r;
      o_cnt_r <= bss_pkg::COUNT_W'(occ_r);
      o_emp_r <= (occ_r == '0);
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.ok        = o_ok_r;
  assign out_ch.value     = o_val_r;
  assign out_ch.count     = o_cnt_r;
  assign out_ch.empty_res = o_emp_r;

endmodule

`default_nettype wire

@@ rtl/core/bss_chk.sv @@
// Port-level checker for the bounded set store, bound to the top level.
`default_nettype none
`include "bounded_set_store_defines.svh"

module bss_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // no result word comes out of reset
  `BSS_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid, "result valid right after reset")

  // one word at a time: busy in the cycle after an accept
  `BSS_ASSERT_ON(a_busy_after_acc, in_valid && in_ready |=> !in_ready, "ready after accept")

  // a result appears only after the sequencer has been busy
  `BSS_ASSERT_ON(a_out_after_work, $rose(out_valid) |-> $past(!in_ready), "result from idle")

  // a stalled result is not dropped
  `BSS_ASSERT_ON(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result lost")

endmodule

bind bounded_set_store bss_chk u_bss_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire
